// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies c in the same cycle, off while reset is high
`define ASSERT_IMPLIES(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error(msg);

// a implies c in the next cycle, off while reset is high
`define ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error(msg);

// a implies c in the next cycle, checked during reset as well
`define ASSERT_NEXT_ALWAYS(label, clk, a, c, msg) \
  label: assert property (@(posedge clk) (a) |=> (c)) \
    else $error(msg);

`endif

// ===== rtl/core/jsfx_pkg.sv =====
// shared types and constants of the json string field extractor
// no dependencies
`timescale 1ns / 1ps

package jsfx_pkg;

  localparam int KEY_CHARS   = 29;
  localparam int KEY_W       = KEY_CHARS * 8;
  localparam int LIMIT_W     = 13;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int RQ_DEPTH    = 4;
  localparam int RQ_PTR_W    = 2;
  localparam int RQ_CNT_W    = 3;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_0_7    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_8_15   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_16_23  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_24_28  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_OUT_LIMIT  = 3'd5;

  // characters
  localparam logic [7:0] CHAR_QUOTE     = 8'h22;
  localparam logic [7:0] CHAR_COLON     = 8'h3a;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
  localparam logic [7:0] CHAR_N         = 8'h6e;
  localparam logic [7:0] CHAR_R         = 8'h72;
  localparam logic [7:0] CHAR_T         = 8'h74;
  localparam logic [7:0] CHAR_LF        = 8'h0a;
  localparam logic [7:0] CHAR_CR        = 8'h0d;
  localparam logic [7:0] CHAR_TAB       = 8'h09;

  localparam logic KIND_VALUE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_COLON,
    PH_SPACES,
    PH_VALUE,
    PH_ESC,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_last;
  } text_item_t;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] value_byte;
    logic       found;
    logic       result_last;
  } result_item_t;

endpackage

// ===== rtl/core/jsfx_window.sv =====
// window of recent text bytes and quoted key compare
// depends on jsfx_pkg
`timescale 1ns / 1ps

module jsfx_window
  import jsfx_pkg::*;
#(
  parameter int MAX_KEY_LEN = 29
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     shift,
  input  logic                     clear,
  input  logic [7:0]               text_byte,
  input  logic [MAX_KEY_LEN*8-1:0] key,
  input  logic [4:0]               key_len,
  output logic                     match
);

  localparam int WD = MAX_KEY_LEN + 2;

  logic [7:0] win     [WD];
  logic [7:0] win_new [WD];

  // window as it stands once the current byte is shifted in
  always_comb begin
    win_new[0] = text_byte;
    for (int i = 1; i < WD; i++) begin
      win_new[i] = win[i-1];
    end
  end

  // newest byte is the closing quote, key char k sits at key_len - k
  always_comb begin
    logic [7:0] want;
    logic       ok;
    logic       close_ok;
    ok       = (win_new[0] == CHAR_QUOTE);
    close_ok = 1'b0;
    for (int p = 1; p < WD; p++) begin
      if ((int'(key_len) + 1 == p) && (win_new[p] == CHAR_QUOTE)) begin
        close_ok = 1'b1;
      end
    end
    for (int p = 1; p <= MAX_KEY_LEN; p++) begin
      want = '0;
      for (int q = 0; q < MAX_KEY_LEN; q++) begin
        if (int'(key_len) == q + p) begin
          want = key[q*8 +: 8];
        end
      end
      if ((int'(key_len) >= p) && (win_new[p] != want)) begin
        ok = 1'b0;
      end
    end
    match = ok && close_ok;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      for (int i = 0; i < WD; i++) begin
        win[i] <= '0;
      end
    end else if (shift) begin
      for (int i = 0; i < WD; i++) begin
        win[i] <= win_new[i];
      end
    end
  end

endmodule

// ===== rtl/core/jsfx_fifo.sv =====
// result queue, up to two writes and one read per cycle
// depends on jsfx_pkg
`timescale 1ns / 1ps

module jsfx_fifo
  import jsfx_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          push_count,
  input  result_item_t        push_item0,
  input  result_item_t        push_item1,
  output logic [RQ_CNT_W-1:0] fill,
  output logic                result_valid,
  input  logic                result_stall,
  output result_item_t        result_item
);

  result_item_t        mem [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wr_ptr;
  logic [RQ_PTR_W-1:0] rd_ptr;
  logic                pop;

  assign result_valid = (fill != '0);
  assign result_item  = mem[rd_ptr];
  assign pop          = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wr_ptr] <= push_item0;
    end
    if (push_count == 2'd2) begin
      mem[wr_ptr + RQ_PTR_W'(1)] <= push_item1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + RQ_PTR_W'(push_count);
      if (pop) begin
        rd_ptr <= rd_ptr + RQ_PTR_W'(1);
      end
      fill <= fill + RQ_CNT_W'(push_count) - RQ_CNT_W'(pop);
    end
  end

endmodule

// ===== rtl/core/json_string_field_extractor_core.sv =====
// Streaming JSON string field extractor. Text enters one byte per transaction
// on the text channel; the block watches for the configured key in double
// quotes, then a colon, optional spaces and an opening quote, and sends each
// value byte (escapes n, r and t decoded, other escaped bytes passed through)
// as a result transaction, followed by one status transaction with result_last
// set, and found set if any value byte was sent, when the text ends (zero byte
// or text_last). A text byte is taken every cycle as long as results drain at
// the same pace: each accepted byte is held in the input register, from which
// it is processed into a four-entry result queue, and its results are offered
// from that queue. The result side moves one transaction per cycle while
// result_stall is low, so a byte that ends the text together with a value byte
// yields two results that leave one after the other; the input stalls while the
// queue has fewer than two free entries. Configuration writes are taken in
// any cycle (cfg_ready is always high) and must only happen while idle.
// depends on jsfx_pkg, jsfx_window, jsfx_fifo
`timescale 1ns / 1ps

module json_string_field_extractor_core
  import jsfx_pkg::*;
#(
  parameter int MAX_KEY_LEN   = 29,
  parameter int OUT_LIMIT_MAX = 4096
) (
  input  logic                   clk,
  input  logic                   rst,
  // text channel
  input  logic                   text_valid,
  output logic                   text_stall,
  input  text_item_t             text_item,
  // result channel
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_item_t           result_item,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // limit cap as seen through the 13-bit out_limit register
  localparam int LIMIT_MAX_REG = (1 << LIMIT_W) - 1;
  localparam int CAP_INT = (OUT_LIMIT_MAX > LIMIT_MAX_REG) ? LIMIT_MAX_REG : OUT_LIMIT_MAX;
  localparam logic [LIMIT_W-1:0] LIMIT_CAP = LIMIT_W'(CAP_INT);
  // copied count stays below the capped limit, and at zero when that limit is zero
  localparam int CW = $clog2(CAP_INT + 1);

  // configuration registers
  logic [63:0]        key_0_7;
  logic [63:0]        key_8_15;
  logic [63:0]        key_16_23;
  logic [39:0]        key_24_28;
  logic [4:0]         key_length;
  logic [LIMIT_W-1:0] out_limit;

  // input register
  logic       in_full;
  text_item_t in_item;

  // text state
  phase_t        phase;
  phase_t        phase_next;
  logic [CW-1:0] copied;
  logic [CW-1:0] copied_next;

  logic [KEY_W-1:0]   key_all;
  logic [4:0]         key_len_eff;
  logic [LIMIT_W-1:0] limit_eff;
  logic               room_left;
  logic               win_match;
  logic               win_shift;
  logic               text_end;
  logic               fire;
  logic               accept;

  // result queue
  logic [RQ_CNT_W-1:0] fill;
  logic [1:0]          push_count;
  result_item_t        push_item0;
  result_item_t        push_item1;
  logic                byte_emit;
  logic [7:0]          byte_val;
  logic [CW-1:0]       copied_final;
  result_item_t        status_item;
  result_item_t        value_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_0_7    <= '0;
      key_8_15   <= '0;
      key_16_23  <= '0;
      key_24_28  <= '0;
      key_length <= '0;
      out_limit  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KEY_0_7:    key_0_7    <= cfg_data;
        REG_KEY_8_15:   key_8_15   <= cfg_data;
        REG_KEY_16_23:  key_16_23  <= cfg_data;
        REG_KEY_24_28:  key_24_28  <= cfg_data[39:0];
        REG_KEY_LENGTH: key_length <= cfg_data[4:0];
        REG_OUT_LIMIT:  out_limit  <= cfg_data[LIMIT_W-1:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // key characters packed low to high, first character in the low byte
  assign key_all     = {key_24_28, key_16_23, key_8_15, key_0_7};
  assign key_len_eff = (int'(key_length) > MAX_KEY_LEN) ? 5'(MAX_KEY_LEN) : key_length;
  assign limit_eff   = (out_limit > LIMIT_CAP) ? LIMIT_CAP : out_limit;
  assign room_left   = ((14'(copied) + 14'd1) < {1'b0, limit_eff});

  // an item is processed only when the queue can take both possible results
  assign fire       = in_full && (fill <= RQ_CNT_W'(RQ_DEPTH - 2));
  assign text_stall = in_full && !fire;
  assign accept     = text_valid && !text_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item <= text_item;
    end
  end

  jsfx_window #(
    .MAX_KEY_LEN(MAX_KEY_LEN)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .shift    (fire && win_shift),
    .clear    (fire && text_end),
    .text_byte(in_item.text_byte),
    .key      (key_all[MAX_KEY_LEN*8-1:0]),
    .key_len  (key_len_eff),
    .match    (win_match)
  );

  // per-byte phase step, then end-of-text handling
  always_comb begin
    phase_next   = phase;
    copied_next  = copied;
    win_shift    = 1'b0;
    byte_emit    = 1'b0;
    byte_val     = in_item.text_byte;
    text_end     = (in_item.text_byte == 8'd0) || in_item.text_last;
    if (in_item.text_byte != 8'd0) begin
      unique case (phase)
        PH_SEARCH: begin
          win_shift = 1'b1;
          if (win_match) begin
            phase_next = PH_COLON;
          end
        end
        PH_COLON: begin
          if (in_item.text_byte == CHAR_COLON) begin
            phase_next = PH_SPACES;
          end
        end
        PH_SPACES: begin
          if (in_item.text_byte == CHAR_QUOTE) begin
            phase_next = PH_VALUE;
          end else if (in_item.text_byte != CHAR_SPACE) begin
            phase_next = PH_DONE;
          end
        end
        PH_VALUE: begin
          if ((in_item.text_byte == CHAR_QUOTE) || !room_left) begin
            phase_next = PH_DONE;
          end else if (in_item.text_byte == CHAR_BACKSLASH) begin
            phase_next = PH_ESC;
          end else begin
            byte_emit   = 1'b1;
            copied_next = copied + CW'(1);
          end
        end
        PH_ESC: begin
          unique case (in_item.text_byte)
            CHAR_N:  byte_val = CHAR_LF;
            CHAR_R:  byte_val = CHAR_CR;
            CHAR_T:  byte_val = CHAR_TAB;
            default: byte_val = in_item.text_byte;
          endcase
          byte_emit   = 1'b1;
          copied_next = copied + CW'(1);
          phase_next  = PH_VALUE;
        end
        default: phase_next = PH_DONE;
      endcase
    end
    // dangling backslash at end of text goes out literally
    if (text_end && (phase_next == PH_ESC)) begin
      byte_emit   = 1'b1;
      byte_val    = CHAR_BACKSLASH;
      copied_next = copied_next + CW'(1);
    end
    copied_final = copied_next;
  end

  always_comb begin
    value_item.item_kind   = KIND_VALUE;
    value_item.value_byte  = byte_val;
    value_item.found       = 1'b0;
    value_item.result_last = 1'b0;

    status_item.item_kind   = KIND_STATUS;
    status_item.value_byte  = 8'd0;
    status_item.found       = (copied_final != '0);
    status_item.result_last = 1'b1;

    push_item0 = byte_emit ? value_item : status_item;
    push_item1 = status_item;
    push_count = 2'd0;
    if (fire) begin
      push_count = 2'(byte_emit) + 2'(text_end);
    end
  end

  // text state returns to reset values once the text-ending byte is processed and its status is queued
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_SEARCH;
      copied <= '0;
    end else if (fire) begin
      if (text_end) begin
        phase  <= PH_SEARCH;
        copied <= '0;
      end else begin
        phase  <= phase_next;
        copied <= copied_next;
      end
    end
  end

  jsfx_fifo u_fifo (
    .clk         (clk),
    .rst         (rst),
    .push_count  (push_count),
    .push_item0  (push_item0),
    .push_item1  (push_item1),
    .fill        (fill),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_item (result_item)
  );

endmodule

// ===== rtl/core/jsfx_checker.sv =====
// port-level checks of the json string field extractor, bound to the top level
// depends on jsfx_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jsfx_checker
  import jsfx_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         result_valid,
  input logic         result_stall,
  input result_item_t result_item
);

  `ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid && $stable(result_item), "stalled result changed")
  `ASSERT_IMPLIES(a_status_form, clk, rst, result_valid && (result_item.item_kind == KIND_STATUS), result_item.result_last && (result_item.value_byte == 8'd0), "malformed status transaction")
  `ASSERT_IMPLIES(a_value_form, clk, rst, result_valid && (result_item.item_kind == KIND_VALUE), !result_item.result_last && !result_item.found && (result_item.value_byte != 8'd0), "malformed value transaction")
  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !result_valid, "result valid right after reset")

endmodule

bind json_string_field_extractor_core jsfx_checker u_jsfx_checker (
  .clk         (clk),
  .rst         (rst),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .result_item (result_item)
);
